[hw/rtl/bsvm_pkg.sv]
// Shared types and codes for the byte stack machine executor.
// No dependencies; used by every module of the block.
package bsvm_pkg;

  localparam int DEF_STACK_BYTES = 4096;
  localparam int DEF_MEM_BYTES   = 1024;

  typedef enum logic [7:0] {
    OP_HALT   = 8'd0,
    OP_PUSHL  = 8'd1,
    OP_PUSHS  = 8'd2,
    OP_PUSHB  = 8'd3,
    OP_POPL   = 8'd4,
    OP_POPS   = 8'd5,
    OP_POPB   = 8'd6,
    OP_WRTL   = 8'd7,
    OP_WRTS   = 8'd8,
    OP_WRTB   = 8'd9,
    OP_STOREL = 8'd10,
    OP_NOP    = 8'd11
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HALT      = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_ILLEGAL   = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_UNDERFLOW = 3'd5,
    ST_BADADDR   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  mode;
    logic [31:0] mem_address;
    logic [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] stack_depth;
    logic [31:0] moved_value;
    logic        is_halted;
  } out_item_t;

endpackage

[hw/rtl/bsvm_stack_mem.sv]
// Byte stack storage split into four byte lanes, one word of up to four bytes
// written and one four-byte word read per cycle. Depends on bsvm_pkg for the default size.
module bsvm_stack_mem #(
  parameter int STACK_BYTES = bsvm_pkg::DEF_STACK_BYTES,
  localparam int AW = $clog2(STACK_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_base,
  input  logic [2:0]    wr_len,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_base,
  output logic [31:0]   rd_data
);

  localparam int ROWS = (STACK_BYTES + 3) / 4;

  logic [3:0][7:0] rd_q;
  logic [1:0]      rd_lo_r;

  for (genvar b = 0; b < 4; b++) begin : g_lane
    logic [7:0]    mem [ROWS];
    logic [1:0]    w_off;
    logic [1:0]    r_off;
    logic [AW-1:0] w_addr;
    logic [AW-1:0] r_addr;
    logic          w_hit;
    logic [7:0]    w_byte;
    logic [7:0]    rd_byte_r;

    // byte offset within the word that lands in this lane
    assign w_off  = 2'(b) - wr_base[1:0];
    assign r_off  = 2'(b) - rd_base[1:0];
    assign w_addr = wr_base + AW'(w_off);
    assign r_addr = rd_base + AW'(r_off);
    assign w_hit  = wr_en && ({1'b0, w_off} < wr_len);
    assign w_byte = wr_data[{w_off, 3'b000} +: 8];

    always_ff @(posedge clk) begin
      if (w_hit) begin
        mem[w_addr[AW-1:2]] <= w_byte;
      end
      if (rd_en) begin
        rd_byte_r <= mem[r_addr[AW-1:2]];
      end
    end

    assign rd_q[b] = rd_byte_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo_r <= rd_base[1:0];
    end
  end

  // rotate lanes back to little-endian order from the base byte
  for (genvar i = 0; i < 4; i++) begin : g_rot
    logic [1:0] lane;
    assign lane = rd_lo_r + 2'(i);
    assign rd_data[8*i +: 8] = rd_q[lane];
  end

endmodule

[hw/rtl/byte_stack_vm_executor_top.sv]
// Top level of the byte stack machine executor: decode, stack pointer,
// halted flag, banked data memory and the result register.
// Depends on bsvm_pkg and bsvm_stack_mem.
//
//   channel | ports                          | carries
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_item    | one decoded instruction
//   out     | out_valid, out_stall, out_item | status, depth, value, halted
//
// One instruction per cycle while the output is not stalled; a result passes
// through stage 1 (stack memory read) and then the output register.
// Pointer and flag update at acceptance, so the next item may follow at once.
// A stalled output freezes the whole pipe and raises in_stall.
// Reset clears pointer, flag and valids; every stack byte from 1 up to the pointer
// has been written since reset, and data memory is never read back.
module byte_stack_vm_executor_top #(
  parameter int STACK_BYTES = bsvm_pkg::DEF_STACK_BYTES,
  parameter int MEM_BYTES   = bsvm_pkg::DEF_MEM_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsvm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bsvm_pkg::out_item_t out_item
);

  import bsvm_pkg::*;

  localparam int TOP_W  = $clog2(STACK_BYTES);
  localparam int DA_W   = $clog2(MEM_BYTES);
  localparam int DROWS  = (MEM_BYTES + 3) / 4;

  // architectural state
  logic [TOP_W-1:0] top_r, top_nxt;
  logic             halted_r, halted_nxt;

  // stage 1 (waiting on the stack read)
  logic             s1_valid_r;
  logic [2:0]       s1_status_r;
  logic [11:0]      s1_depth_r;
  logic [31:0]      s1_moved_r;
  logic             s1_halt_r;
  logic             s1_storel_r;
  logic             s1_dwr_r;
  logic [DA_W-1:0]  s1_daddr_r;
  logic [2:0]       s1_len_r;

  logic             out_valid_r;
  out_item_t        out_item_r;

  logic             adv;
  logic             accept;

  // decode outputs
  status_t          status;
  logic [2:0]       len;
  logic [31:0]      low_val;
  logic [31:0]      moved;
  logic             push_we;
  logic             pop_rd;
  logic             dwr;
  logic [2:0]       dlen;
  logic [31:0]      depth32;
  logic [31:0]      rd_data;
  logic [31:0]      s1_value;

  assign adv      = !out_valid_r || !out_stall;
  assign accept   = in_valid && adv;
  assign in_stall = !adv;

  always_comb begin
    case (in_item.mode)
      OP_PUSHL, OP_POPL, OP_WRTL: len = 3'd4;
      OP_PUSHS, OP_POPS, OP_WRTS: len = 3'd2;
      OP_PUSHB, OP_POPB, OP_WRTB: len = 3'd1;
      default:                    len = 3'd4;
    endcase
  end

  always_comb begin
    case (len)
      3'd1:    low_val = {24'd0, in_item.immediate[7:0]};
      3'd2:    low_val = {16'd0, in_item.immediate[15:0]};
      default: low_val = in_item.immediate;
    endcase
  end

  always_comb begin
    status     = ST_OK;
    top_nxt    = top_r;
    halted_nxt = halted_r;
    moved      = 32'd0;
    push_we    = 1'b0;
    pop_rd     = 1'b0;
    dwr        = 1'b0;
    dlen       = len;
    if (halted_r) begin
      status = ST_IGNORED;
    end else begin
      case (in_item.mode)
        OP_HALT: begin
          status     = ST_HALT;
          halted_nxt = 1'b1;
        end
        OP_PUSHL, OP_PUSHS, OP_PUSHB: begin
          if (32'(top_r) + 32'(len) >= 32'(STACK_BYTES)) begin
            status = ST_OVERFLOW;
          end else begin
            top_nxt = top_r + TOP_W'(len);
            push_we = 1'b1;
            moved   = low_val;
          end
        end
        OP_POPL, OP_POPS, OP_POPB: begin
          if (32'(top_r) < 32'(len)) begin
            status = ST_UNDERFLOW;
          end else begin
            top_nxt = top_r - TOP_W'(len);
          end
        end
        OP_WRTL, OP_WRTS, OP_WRTB: begin
          if ({1'b0, in_item.mem_address} + 33'(len) > 33'(MEM_BYTES)) begin
            status = ST_BADADDR;
          end else begin
            dwr   = 1'b1;
            moved = low_val;
          end
        end
        OP_STOREL: begin
          dlen = 3'd4;
          if (32'(top_r) < 32'd4) begin
            status = ST_UNDERFLOW;
          end else if ({1'b0, in_item.mem_address} + 33'd4 > 33'(MEM_BYTES)) begin
            status = ST_BADADDR;
          end else begin
            top_nxt = top_r - TOP_W'(4);
            pop_rd  = 1'b1;
            dwr     = 1'b1;
          end
        end
        OP_NOP: begin
          status = ST_OK;
        end
        default: begin
          status     = ST_ILLEGAL;
          halted_nxt = 1'b1;
        end
      endcase
    end
  end

  assign depth32 = 32'(top_nxt);

  bsvm_stack_mem #(
    .STACK_BYTES(STACK_BYTES)
  ) u_stack (
    .clk     (clk),
    .wr_en   (accept && push_we),
    .wr_base (top_r + TOP_W'(1)),
    .wr_len  (len),
    .wr_data (in_item.immediate),
    .rd_en   (accept && pop_rd),
    .rd_base (top_r - TOP_W'(3)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      halted_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        top_r    <= top_nxt;
        halted_r <= halted_nxt;
      end
      if (adv) begin
        s1_valid_r  <= accept;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
      s1_depth_r  <= depth32[11:0];
      s1_moved_r  <= moved;
      s1_halt_r   <= halted_nxt;
      s1_storel_r <= pop_rd;
      s1_dwr_r    <= dwr;
      s1_daddr_r  <= in_item.mem_address[DA_W-1:0];
      s1_len_r    <= dlen;
    end
  end

  assign s1_value = s1_storel_r ? rd_data : s1_moved_r;

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_item_r.status      <= s1_status_r;
      out_item_r.stack_depth <= s1_depth_r;
      out_item_r.moved_value <= s1_value;
      out_item_r.is_halted   <= s1_halt_r;
    end
  end

  // data memory: four byte lanes, written in order as items leave stage 1
  for (genvar b = 0; b < 4; b++) begin : g_dlane
    logic [7:0]      dmem [DROWS];
    logic [1:0]      off;
    logic [DA_W-1:0] addr;
    logic            hit;

    assign off  = 2'(b) - s1_daddr_r[1:0];
    assign addr = s1_daddr_r + DA_W'(off);
    assign hit  = adv && s1_valid_r && s1_dwr_r && ({1'b0, off} < s1_len_r);

    always_ff @(posedge clk) begin
      if (hit) begin
        dmem[addr[DA_W-1:2]] <= s1_value[{off, 3'b000} +: 8];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
